// File: src/dcm_rk4_pkg.sv
// Shared types and constants for the DC motor RK4 plant stepper.
// Used by dc_motor_rk4_plant_step; depends on nothing else.
package dcm_rk4_pkg;

  localparam int unsigned QW       = 48;  // signed Q16.32 word
  localparam int unsigned CFG_W    = 47;  // configuration register width
  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned MAX_MICRO_STEPS_DEF = 255;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SUPPLY_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_TIME_STEP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_INV_L        = 3'd2;
  localparam logic [IDX_W-1:0] REG_R_OVER_L     = 3'd3;
  localparam logic [IDX_W-1:0] REG_KE_OVER_L    = 3'd4;
  localparam logic [IDX_W-1:0] REG_KT_OVER_J    = 3'd5;
  localparam logic [IDX_W-1:0] REG_B_OVER_J     = 3'd6;

  typedef struct packed {
    logic signed [QW-1:0] volt_command;
    logic [7:0]           step_count;
  } req_t;

  typedef struct packed {
    logic signed [QW-1:0] current_out;
    logic signed [QW-1:0] speed_out;
    logic                 guard_hit;
  } rsp_t;

endpackage

// File: src/dc_motor_rk4_plant_step.sv
// DC motor plant stepper: fourth-order Runge-Kutta on armature current and shaft speed.
// Depends on dcm_rk4_pkg for the request/response structs and register indexes.

// A request clamps the voltage command to the supply limit and advances the stored
// current and speed by step_count RK4 micro-steps (capped at MAX_MICRO_STEPS). All
// products run through one shared 26x24-bit multiplier that builds each 51x47-bit
// product from four partial products. out_valid_o rises once the request has run
// one product for dt/6 (dt/2 times a reciprocal of three), one for the voltage term,
// then 24 products per micro-step. in_stall_o stays high until the response is taken.
module dc_motor_rk4_plant_step #(
  parameter int unsigned MAX_MICRO_STEPS = dcm_rk4_pkg::MAX_MICRO_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dcm_rk4_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [dcm_rk4_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dcm_rk4_pkg::req_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dcm_rk4_pkg::rsp_t                out_data_o
);
  import dcm_rk4_pkg::*;

  localparam int unsigned N_CAP = (MAX_MICRO_STEPS > 255) ? 255 : MAX_MICRO_STEPS;

  // (2^47 + 1) / 3: floor(x * RECIP3 / 2^47) equals floor(x / 3) for x below 2^47
  localparam logic [CFG_W-1:0] RECIP3 = 47'd46912496118443;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPND = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_RET  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [2:0] OP_B   = 3'd0;  // R/L * i
  localparam logic [2:0] OP_C   = 3'd1;  // Ke/L * w
  localparam logic [2:0] OP_D   = 3'd2;  // Kt/J * i
  localparam logic [2:0] OP_E   = 3'd3;  // B/J * w, then form slopes
  localparam logic [2:0] OP_PI  = 3'd4;  // next current point or update
  localparam logic [2:0] OP_PW  = 3'd5;  // next speed point or update
  localparam logic [2:0] OP_V   = 3'd6;  // v * 1/L, once per request
  localparam logic [2:0] OP_SIX = 3'd7;  // dt/6, once per request

  logic [2:0]  state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [1:0]  stg_q, stg_d;
  logic [1:0]  pp_q;
  logic [7:0]  cnt_q, cnt_d;
  logic [CFG_W-1:0] cfg_q [NUM_REGS];

  logic signed [QW-1:0] v_q, vt_q, vt_d;
  logic                 vt_b_q, vt_b_d;
  logic [CFG_W-1:0]     sixth_q;
  logic signed [QW-1:0] ci_q, ci_d, cw_q, cw_d;
  logic signed [QW-1:0] pi_q, pi_d, pw_q, pw_d;
  logic                 pi_b_q, pi_b_d, pw_b_q, pw_b_d;
  logic signed [QW-1:0] tb_q, tb_d, tc_q, tc_d, td_q, td_d;
  logic                 tb_b_q, tb_b_d, tc_b_q, tc_b_d, td_b_q, td_b_d;
  logic signed [QW-1:0] ki_q, ki_d, kw_q, kw_d;
  logic                 ki_b_q, ki_b_d, kw_b_q, kw_b_d;
  logic signed [50:0]   si_q, si_d, sw_q, sw_d;
  logic                 bi_q, bi_d, bw_q, bw_d;
  logic                 guard_q, guard_d;

  logic [50:0]  ua_q;
  logic [46:0]  ub_q;
  logic         neg_q, bin_q;
  logic [97:0]  acc_q;

  // Operand selection
  logic signed [50:0] a_sel;
  logic [46:0]        b_sel, half;
  logic               bin_sel;

  assign half = {1'b0, cfg_q[REG_TIME_STEP][CFG_W-1:1]};

  always_comb begin
    a_sel   = {{3{pi_q[QW-1]}}, pi_q};
    b_sel   = cfg_q[REG_R_OVER_L];
    bin_sel = pi_b_q;
    case (op_q)
      OP_SIX: begin
        a_sel   = {4'b0000, half};
        b_sel   = RECIP3;
        bin_sel = 1'b0;
      end
      OP_V: begin
        a_sel   = {{3{v_q[QW-1]}}, v_q};
        b_sel   = cfg_q[REG_INV_L];
        bin_sel = 1'b0;
      end
      OP_B: begin
        a_sel   = {{3{pi_q[QW-1]}}, pi_q};
        b_sel   = cfg_q[REG_R_OVER_L];
        bin_sel = pi_b_q;
      end
      OP_C: begin
        a_sel   = {{3{pw_q[QW-1]}}, pw_q};
        b_sel   = cfg_q[REG_KE_OVER_L];
        bin_sel = pw_b_q;
      end
      OP_D: begin
        a_sel   = {{3{pi_q[QW-1]}}, pi_q};
        b_sel   = cfg_q[REG_KT_OVER_J];
        bin_sel = pi_b_q;
      end
      OP_E: begin
        a_sel   = {{3{pw_q[QW-1]}}, pw_q};
        b_sel   = cfg_q[REG_B_OVER_J];
        bin_sel = pw_b_q;
      end
      OP_PI: begin
        a_sel   = (stg_q == 2'd3) ? si_q : {{3{ki_q[QW-1]}}, ki_q};
        bin_sel = (stg_q == 2'd3) ? bi_q : ki_b_q;
        b_sel   = (stg_q == 2'd3) ? sixth_q :
                  (stg_q == 2'd2) ? cfg_q[REG_TIME_STEP] : half;
      end
      OP_PW: begin
        a_sel   = (stg_q == 2'd3) ? sw_q : {{3{kw_q[QW-1]}}, kw_q};
        bin_sel = (stg_q == 2'd3) ? bw_q : kw_b_q;
        b_sel   = (stg_q == 2'd3) ? sixth_q :
                  (stg_q == 2'd2) ? cfg_q[REG_TIME_STEP] : half;
      end
      default: ;
    endcase
  end

  // Shared multiplier: one 26x24 partial product per cycle
  logic [25:0] a_part;
  logic [23:0] b_part;
  logic [49:0] pprod;
  logic [97:0] pshift;

  assign a_part = pp_q[1] ? {1'b0, ua_q[50:26]} : ua_q[25:0];
  assign b_part = pp_q[0] ? {1'b0, ub_q[46:24]} : ub_q[23:0];
  assign pprod  = 50'(a_part) * 50'(b_part);

  always_comb begin
    case (pp_q)
      2'd0:    pshift = 98'(pprod);
      2'd1:    pshift = 98'(pprod) << 24;
      2'd2:    pshift = 98'(pprod) << 26;
      default: pshift = 98'(pprod) << 50;
    endcase
  end

  // Product: magnitude >> 32, must fit the signed word
  logic              ok_mag, prod_b;
  logic [QW-1:0]     mag48;
  logic signed [QW-1:0] prod_v;

  assign ok_mag = (acc_q[97:79] == 19'd0) ||
                  (neg_q && acc_q[97:79] == 19'd1 && acc_q[78:32] == 47'd0);
  assign mag48  = acc_q[79:32];
  assign prod_v = neg_q ? -$signed(mag48) : $signed(mag48);
  assign prod_b = bin_q || !ok_mag;

  // Retire arithmetic
  logic signed [49:0] di_full;
  logic signed [48:0] dw_full, psum_i, psum_w;
  logic               di_fit, dw_fit, pi_fit, pw_fit, ni_bad, nw_bad;
  logic               kib_new, kwb_new;
  logic signed [50:0] ki_ext, kw_ext;

  assign di_full = {{2{vt_q[QW-1]}}, vt_q} - {{2{tb_q[QW-1]}}, tb_q}
                 - {{2{tc_q[QW-1]}}, tc_q};
  assign dw_full = {td_q[QW-1], td_q} - {prod_v[QW-1], prod_v};
  assign di_fit  = (di_full[49:47] == 3'b000) || (di_full[49:47] == 3'b111);
  assign dw_fit  = (dw_full[48] == dw_full[47]);
  assign kib_new = vt_b_q || tb_b_q || tc_b_q || !di_fit;
  assign kwb_new = td_b_q || prod_b || !dw_fit;
  assign ki_ext  = {{3{di_full[47]}}, di_full[47:0]};
  assign kw_ext  = {{3{dw_full[47]}}, dw_full[47:0]};

  assign psum_i = {ci_q[QW-1], ci_q} + {prod_v[QW-1], prod_v};
  assign psum_w = {cw_q[QW-1], cw_q} + {prod_v[QW-1], prod_v};
  assign pi_fit = (psum_i[48] == psum_i[47]);
  assign pw_fit = (psum_w[48] == psum_w[47]);
  assign ni_bad = prod_b || !pi_fit;
  assign nw_bad = prod_b || !pw_fit;

  // Request capture
  logic               in_acc;
  logic signed [48:0] v_ext, vs_ext;
  logic signed [QW-1:0] v_clamp;
  logic [7:0]         n_cap;

  assign in_acc = in_valid_i && !in_stall_o;
  assign v_ext  = {in_data_i.volt_command[QW-1], in_data_i.volt_command};
  assign vs_ext = {2'b00, cfg_q[REG_SUPPLY_LIMIT]};
  assign n_cap  = (in_data_i.step_count > 8'(N_CAP)) ? 8'(N_CAP) : in_data_i.step_count;

  always_comb begin
    if (v_ext > vs_ext) begin
      v_clamp = 48'(vs_ext);
    end else if (v_ext < -vs_ext) begin
      v_clamp = 48'(-vs_ext);
    end else begin
      v_clamp = in_data_i.volt_command;
    end
  end

  // Sequencer next state and retire actions
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    stg_d   = stg_q;
    cnt_d   = cnt_q;
    vt_d = vt_q;  vt_b_d = vt_b_q;
    ci_d = ci_q;  cw_d = cw_q;
    pi_d = pi_q;  pi_b_d = pi_b_q;
    pw_d = pw_q;  pw_b_d = pw_b_q;
    tb_d = tb_q;  tb_b_d = tb_b_q;
    tc_d = tc_q;  tc_b_d = tc_b_q;
    td_d = td_q;  td_b_d = td_b_q;
    ki_d = ki_q;  ki_b_d = ki_b_q;
    kw_d = kw_q;  kw_b_d = kw_b_q;
    si_d = si_q;  bi_d = bi_q;
    sw_d = sw_q;  bw_d = bw_q;
    guard_d = guard_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_OPND;
          op_d    = OP_SIX;
          stg_d   = 2'd0;
          cnt_d   = n_cap;
          pi_d    = ci_q;
          pw_d    = cw_q;
          pi_b_d  = 1'b0;
          pw_b_d  = 1'b0;
          guard_d = 1'b0;
        end
      end
      S_OPND: state_d = S_MUL;
      S_MUL: begin
        if (pp_q == 2'd3) begin
          state_d = S_RET;
        end
      end
      S_RET: begin
        state_d = S_OPND;
        op_d    = op_q + 3'd1;
        case (op_q)
          OP_SIX: begin
            op_d = OP_V;
          end
          OP_V: begin
            vt_d   = prod_v;
            vt_b_d = prod_b;
            op_d   = OP_B;
            if (cnt_q == 8'd0) begin
              state_d = S_OUT;
            end
          end
          OP_B: begin
            tb_d = prod_v;  tb_b_d = prod_b;
          end
          OP_C: begin
            tc_d = prod_v;  tc_b_d = prod_b;
          end
          OP_D: begin
            td_d = prod_v;  td_b_d = prod_b;
          end
          OP_E: begin
            ki_d   = di_full[47:0];
            ki_b_d = kib_new;
            kw_d   = dw_full[47:0];
            kw_b_d = kwb_new;
            // weights 1,2,2,1
            if (stg_q == 2'd0) begin
              si_d = ki_ext;
              sw_d = kw_ext;
              bi_d = kib_new;
              bw_d = kwb_new;
            end else begin
              si_d = (stg_q == 2'd3) ? si_q + ki_ext : si_q + (ki_ext <<< 1);
              sw_d = (stg_q == 2'd3) ? sw_q + kw_ext : sw_q + (kw_ext <<< 1);
              bi_d = bi_q || kib_new;
              bw_d = bw_q || kwb_new;
            end
          end
          OP_PI: begin
            if (stg_q == 2'd3) begin
              // overflowing update drops to zero
              ci_d = ni_bad ? '0 : psum_i[47:0];
              if (ni_bad) begin
                guard_d = 1'b1;
              end
            end else begin
              pi_d   = psum_i[47:0];
              pi_b_d = ni_bad;
            end
          end
          OP_PW: begin
            op_d = OP_B;
            if (stg_q == 2'd3) begin
              cw_d   = nw_bad ? '0 : psum_w[47:0];
              pw_d   = nw_bad ? '0 : psum_w[47:0];
              pi_d   = ci_q;
              pi_b_d = 1'b0;
              pw_b_d = 1'b0;
              if (nw_bad) begin
                guard_d = 1'b1;
              end
              stg_d = 2'd0;
              cnt_d = cnt_q - 8'd1;
              if (cnt_q == 8'd1) begin
                state_d = S_OUT;
              end
            end else begin
              pw_d   = psum_w[47:0];
              pw_b_d = nw_bad;
              stg_d  = stg_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_V;
      stg_q     <= 2'd0;
      cnt_q     <= 8'd0;
      pp_q      <= 2'd0;
      ci_q      <= '0;
      cw_q      <= '0;
      guard_q   <= 1'b0;
      for (int k = 0; k < NUM_REGS; k++) begin
        cfg_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      stg_q   <= stg_d;
      cnt_q   <= cnt_d;
      ci_q    <= ci_d;
      cw_q    <= cw_d;
      guard_q <= guard_d;
      if (state_q == S_MUL) begin
        pp_q <= pp_q + 2'd1;
      end else begin
        pp_q <= 2'd0;
      end
      if (cfg_we_i && (cfg_idx_i < IDX_W'(NUM_REGS))) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    vt_q <= vt_d;  vt_b_q <= vt_b_d;
    pi_q <= pi_d;  pi_b_q <= pi_b_d;
    pw_q <= pw_d;  pw_b_q <= pw_b_d;
    tb_q <= tb_d;  tb_b_q <= tb_b_d;
    tc_q <= tc_d;  tc_b_q <= tc_b_d;
    td_q <= td_d;  td_b_q <= td_b_d;
    ki_q <= ki_d;  ki_b_q <= ki_b_d;
    kw_q <= kw_d;  kw_b_q <= kw_b_d;
    si_q <= si_d;  bi_q <= bi_d;
    sw_q <= sw_d;  bw_q <= bw_d;
    if (in_acc) begin
      v_q <= v_clamp;
    end
    if (state_q == S_RET && op_q == OP_SIX) begin
      // (dt/2) * RECIP3 >> 47 gives dt/6
      sixth_q <= acc_q[93:47];
    end
    if (state_q == S_OPND) begin
      ua_q  <= a_sel[50] ? 51'(-a_sel) : 51'(a_sel);
      ub_q  <= b_sel;
      neg_q <= a_sel[50];
      bin_q <= bin_sel;
      acc_q <= '0;
    end else if (state_q == S_MUL) begin
      acc_q <= acc_q + pshift;
    end
  end

  assign in_stall_o             = (state_q != S_IDLE);
  assign out_valid_o            = (state_q == S_OUT);
  assign out_data_o.current_out = ci_q;
  assign out_data_o.speed_out   = cw_q;
  assign out_data_o.guard_hit   = guard_q;

endmodule
